/* rtl/core/assert_macros.svh */
// assertion macros shared by the interval coverage merge rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ICM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds through reset
`define ICM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/icm_pkg.sv */
// types and constants of the interval coverage merge block
// no dependencies; used by the interfaces and every module but icm_queue
package icm_pkg;

    localparam int COUNT_BITS = 40;

    typedef enum logic [0:0] {
        OP_INTERVAL = 1'b0,
        OP_END      = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_INTERVAL  = 2'd0,
        KIND_COVERED   = 2'd1,
        KIND_UNCOVERED = 2'd2,
        KIND_OVERHANG  = 2'd3
    } t_kind;

endpackage

/* rtl/core/icm_if.sv */
// valid/ready channels of the interval coverage merge block
// depends on icm_pkg
interface icm_in_if import icm_pkg::*; #(
    parameter int POSITION_BITS = 31
) ();
    logic                     valid;
    logic                     ready;
    logic [0:0]               operation;
    logic [POSITION_BITS-1:0] interval_begin;
    logic [POSITION_BITS-1:0] interval_end;
    logic [POSITION_BITS-1:0] contig_length;
    logic                     is_oriented;
    logic                     has_label;
    logic                     has_score;

    modport source (
        output valid, operation, interval_begin, interval_end, contig_length,
               is_oriented, has_label, has_score,
        input  ready
    );
    modport sink (
        input  valid, operation, interval_begin, interval_end, contig_length,
               is_oriented, has_label, has_score,
        output ready
    );
endinterface

interface icm_out_if import icm_pkg::*; #(
    parameter int POSITION_BITS = 31,
    parameter int TOTAL_BITS    = 48
) ();
    logic                     valid;
    logic                     ready;
    t_kind                    result_kind;
    logic [POSITION_BITS-1:0] length;
    logic                     last_of_run;
    logic [TOTAL_BITS-1:0]    sum_intervals;
    logic [TOTAL_BITS-1:0]    sum_covered;
    logic [TOTAL_BITS-1:0]    sum_uncovered;
    logic [TOTAL_BITS-1:0]    sum_overhang;
    logic [COUNT_BITS-1:0]    oriented_count;
    logic [COUNT_BITS-1:0]    labelled_count;
    logic [COUNT_BITS-1:0]    scored_count;

    modport source (
        output valid, result_kind, length, last_of_run, sum_intervals, sum_covered,
               sum_uncovered, sum_overhang, oriented_count, labelled_count, scored_count,
        input  ready
    );
    modport sink (
        input  valid, result_kind, length, last_of_run, sum_intervals, sum_covered,
               sum_uncovered, sum_overhang, oriented_count, labelled_count, scored_count,
        output ready
    );
endinterface

/* rtl/core/icm_queue.sv */
// two-entry job queue between the classifying front and the result back end
// depends on assert_macros.svh
`include "assert_macros.svh"

module icm_queue #(
    parameter int WIDTH = 228
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    `ICM_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full, "push into full queue")
    `ICM_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid, "pop from empty queue")
    `ICM_ASSERT(a_count_step, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count did not rise on push")

endmodule

/* rtl/core/icm_front.sv */
// front end: takes items, tracks the open block and turns each item with results into a job
// depends on icm_pkg, icm_if and assert_macros.svh
`include "assert_macros.svh"

module icm_front import icm_pkg::*; #(
    parameter int POSITION_BITS = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    icm_in_if.sink                 i_in,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [7*POSITION_BITS+11-1:0] o_job
);
    localparam int PB = POSITION_BITS;

    typedef struct packed {
        logic [1:0]    res_n;
        t_kind         kind0, kind1, kind2;
        logic [PB-1:0] len0, len1, len2;
        logic [PB-1:0] add_int, add_cov, add_unc, add_ovh;
        logic          inc_ori, inc_lab, inc_sco;
    } t_job;

    logic [PB-1:0] r_start;
    logic [PB-1:0] r_stop;
    logic          r_open;
    logic [PB-1:0] n_start;
    logic [PB-1:0] n_stop;
    logic          n_open;

    logic [PB-1:0] iv_beg, iv_end, ctg_len;
    logic [PB-1:0] iv_len, blk_len;
    logic          acc;
    logic          has_job;
    t_job          job;

    assign iv_beg  = i_in.interval_begin;
    assign iv_end  = i_in.interval_end;
    assign ctg_len = i_in.contig_length;
    assign iv_len  = (iv_end > iv_beg) ? iv_end - iv_beg : '0;
    assign blk_len = (r_stop > r_start) ? r_stop - r_start : '0;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;

    always_comb begin
        job     = '0;
        job.kind0 = KIND_INTERVAL;
        job.kind1 = KIND_INTERVAL;
        job.kind2 = KIND_INTERVAL;
        has_job = 1'b0;
        n_start = r_start;
        n_stop  = r_stop;
        n_open  = r_open;
        case (i_in.operation)
            OP_INTERVAL: begin
                has_job     = 1'b1;
                job.inc_ori = i_in.is_oriented;
                job.inc_lab = i_in.has_label;
                job.inc_sco = i_in.has_score;
                job.add_int = iv_len;
                if (!r_open) begin
                    // first interval of the contig, leading stretch after it
                    job.len0  = iv_len;
                    job.kind1 = KIND_UNCOVERED;
                    job.len1  = iv_beg;
                    job.add_unc = iv_beg;
                    job.res_n = (iv_beg != '0) ? 2'd2 : 2'd1;
                    n_start = iv_beg;
                    n_stop  = iv_end;
                    n_open  = 1'b1;
                end else if (r_stop < iv_beg) begin
                    // block closes, gap, then the new interval
                    job.kind0   = KIND_COVERED;
                    job.len0    = blk_len;
                    job.kind1   = KIND_UNCOVERED;
                    job.len1    = iv_beg - r_stop;
                    job.len2    = iv_len;
                    job.add_cov = blk_len;
                    job.add_unc = iv_beg - r_stop;
                    job.res_n   = 2'd3;
                    n_start = iv_beg;
                    n_stop  = iv_end;
                end else begin
                    job.len0  = iv_len;
                    job.res_n = 2'd1;
                    if (iv_end > r_stop) begin
                        n_stop = iv_end;
                    end
                end
            end
            OP_END: begin
                if (r_open) begin
                    has_job     = 1'b1;
                    job.kind0   = KIND_COVERED;
                    job.len0    = blk_len;
                    job.add_cov = blk_len;
                    job.res_n   = 2'd1;
                    if (r_stop < ctg_len) begin
                        job.kind1   = KIND_UNCOVERED;
                        job.len1    = ctg_len - r_stop;
                        job.add_unc = ctg_len - r_stop;
                        job.res_n   = 2'd2;
                    end else if (r_stop > ctg_len) begin
                        job.kind1   = KIND_OVERHANG;
                        job.len1    = r_stop - ctg_len;
                        job.add_ovh = r_stop - ctg_len;
                        job.res_n   = 2'd2;
                    end
                    n_open = 1'b0;
                end
            end
            default: begin
                has_job = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (acc) begin
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_start <= n_start;
            r_stop  <= n_stop;
        end
    end

    assign o_push = acc && has_job;
    assign o_job  = job;

    `ICM_ASSERT(a_open_after_iv, i_clk, i_rst_n, (acc && (i_in.operation == OP_INTERVAL)) |=> r_open, "contig not open after interval")
    `ICM_ASSERT(a_iv_makes_job, i_clk, i_rst_n, (acc && (i_in.operation == OP_INTERVAL)) |-> (o_push && (job.res_n != 2'd0)), "interval gave no results")
    `ICM_ASSERT(a_closed_no_job, i_clk, i_rst_n, (acc && !r_open && (i_in.operation == OP_END)) |-> !o_push, "end of closed contig made a job")

endmodule

/* rtl/core/icm_back.sv */
// back end: updates the saturating totals per job and hands out its results
// depends on icm_pkg, icm_if and assert_macros.svh
`include "assert_macros.svh"

module icm_back import icm_pkg::*; #(
    parameter int POSITION_BITS = 31,
    parameter int TOTAL_BITS    = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic [7*POSITION_BITS+11-1:0] i_job,
    output logic                          o_pop,
    icm_out_if.source                     o_out
);
    localparam int PB    = POSITION_BITS;
    localparam int TB    = TOTAL_BITS;
    localparam int SUM_W = ((TB > PB) ? TB : PB) + 1;

    typedef struct packed {
        logic [1:0]    res_n;
        t_kind         kind0, kind1, kind2;
        logic [PB-1:0] len0, len1, len2;
        logic [PB-1:0] add_int, add_cov, add_unc, add_ovh;
        logic          inc_ori, inc_lab, inc_sco;
    } t_job;

    function automatic logic [TB-1:0] sat_tot(input logic [TB-1:0] tot,
                                              input logic [PB-1:0] x);
        logic [SUM_W-1:0] s;
        s = SUM_W'(tot) + SUM_W'(x);
        return (s > SUM_W'({TB{1'b1}})) ? {TB{1'b1}} : s[TB-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] cnt,
                                                      input logic inc);
        return (inc && (cnt != {COUNT_BITS{1'b1}})) ? cnt + 1'b1 : cnt;
    endfunction

    t_job                  job;
    logic                  r_busy;
    logic [1:0]            r_left;
    t_kind                 r_kind [3];
    logic [PB-1:0]         r_len [3];
    logic [TB-1:0]         r_sum_int, r_sum_cov, r_sum_unc, r_sum_ovh;
    logic [COUNT_BITS-1:0] r_cnt_ori, r_cnt_lab, r_cnt_sco;
    logic                  out_acc;
    logic                  last;
    logic                  take;

    assign job     = t_job'(i_job);
    assign out_acc = r_busy && o_out.ready;
    assign last    = (r_left == 2'd1);
    // next job loads as the last result of the current one leaves
    assign take    = i_q_valid && (!r_busy || (out_acc && last));
    assign o_pop   = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_left    <= '0;
            r_sum_int <= '0;
            r_sum_cov <= '0;
            r_sum_unc <= '0;
            r_sum_ovh <= '0;
            r_cnt_ori <= '0;
            r_cnt_lab <= '0;
            r_cnt_sco <= '0;
        end else if (take) begin
            r_busy    <= 1'b1;
            r_left    <= job.res_n;
            r_sum_int <= sat_tot(r_sum_int, job.add_int);
            r_sum_cov <= sat_tot(r_sum_cov, job.add_cov);
            r_sum_unc <= sat_tot(r_sum_unc, job.add_unc);
            r_sum_ovh <= sat_tot(r_sum_ovh, job.add_ovh);
            r_cnt_ori <= sat_cnt(r_cnt_ori, job.inc_ori);
            r_cnt_lab <= sat_cnt(r_cnt_lab, job.inc_lab);
            r_cnt_sco <= sat_cnt(r_cnt_sco, job.inc_sco);
        end else if (out_acc) begin
            r_left <= r_left - 1'b1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // result slots shift down so the head is always slot 0
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind[0] <= job.kind0;
            r_kind[1] <= job.kind1;
            r_kind[2] <= job.kind2;
            r_len[0]  <= job.len0;
            r_len[1]  <= job.len1;
            r_len[2]  <= job.len2;
        end else if (out_acc) begin
            r_kind[0] <= r_kind[1];
            r_kind[1] <= r_kind[2];
            r_len[0]  <= r_len[1];
            r_len[1]  <= r_len[2];
        end
    end

    assign o_out.valid          = r_busy;
    assign o_out.result_kind    = r_kind[0];
    assign o_out.length         = r_len[0];
    assign o_out.last_of_run    = last;
    assign o_out.sum_intervals  = r_sum_int;
    assign o_out.sum_covered    = r_sum_cov;
    assign o_out.sum_uncovered  = r_sum_unc;
    assign o_out.sum_overhang   = r_sum_ovh;
    assign o_out.oriented_count = r_cnt_ori;
    assign o_out.labelled_count = r_cnt_lab;
    assign o_out.scored_count   = r_cnt_sco;

    `ICM_ASSERT(a_busy_left, i_clk, i_rst_n, r_busy |-> (r_left != 2'd0), "busy with no results left")
    `ICM_ASSERT(a_totals_hold, i_clk, i_rst_n, (out_acc && !last) |=> ($stable(r_sum_int) && $stable(r_sum_cov) && $stable(r_sum_unc) && $stable(r_sum_ovh)), "totals moved within a run")
    `ICM_ASSERT(a_sum_mono, i_clk, i_rst_n, take |=> ((r_sum_int >= $past(r_sum_int)) && (r_sum_cov >= $past(r_sum_cov))), "running total went down")

endmodule

/* rtl/core/interval_coverage_merge.sv */
// top level of the interval coverage merge block: front, job queue and back end
// depends on icm_pkg, icm_if, icm_queue, icm_front and icm_back
//
//  port    dir  what travels
//  i_in    in   one interval or end-of-contig item
//  o_out   out  one result: kind, length, last flag, running totals and counts
//
// an item is taken while the two-entry job queue has room; its job is held
// in the queue, then in the back end until its k results (one to three) have
// left, one per cycle while o_out.ready is high
// reset clears the open contig, the queue and all totals
// a stalled result channel fills the queue, then i_in.ready drops
module interval_coverage_merge import icm_pkg::*; #(
    parameter int POSITION_BITS = 31,
    parameter int TOTAL_BITS    = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    icm_in_if.sink    i_in,
    icm_out_if.source o_out
);
    localparam int JOB_W = 7 * POSITION_BITS + 11;

    logic             push;
    logic             pop;
    logic             q_valid;
    logic             q_full;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;

    icm_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (job_in)
    );

    icm_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (job_out)
    );

    icm_back #(
        .POSITION_BITS (POSITION_BITS),
        .TOTAL_BITS    (TOTAL_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (job_out),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// self-checking bench for interval_coverage_merge: a predictor checks every result
// depends on icm_pkg, icm_in_if, icm_out_if and interval_coverage_merge from the rtl
module tb_top;
    import icm_pkg::*;

    localparam int          POS_W        = 31;
    localparam int          TOT_W        = 48;
    localparam int          PHASE_ITEMS  = 90;
    localparam int          DRAIN_CYCLES = 8;
    localparam longint      CYCLE_LIMIT  = 3_000_000;

    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [TOT_W-1:0]      t_total;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_pos POS_MAX = {POS_W{1'b1}};

    typedef struct packed {
        t_op  op;
        t_pos begin_pos;
        t_pos end_pos;
        t_pos clen;
        logic oriented;
        logic labelled;
        logic scored;
    } t_request;

    typedef struct packed {
        t_kind  kind;
        t_pos   len;
        logic   last;
        t_total sum_iv;
        t_total sum_cov;
        t_total sum_unc;
        t_total sum_ovh;
        t_count n_oriented;
        t_count n_labelled;
        t_count n_scored;
    } t_result;

    class coverage_merger;
        t_pos        blk_lo;
        t_pos        blk_hi;
        bit          contig_active;
        t_total      total_iv;
        t_total      total_cov;
        t_total      total_unc;
        t_total      total_ovh;
        t_count      cnt_oriented;
        t_count      cnt_labelled;
        t_count      cnt_scored;
        t_kind       run_kinds[$];
        t_pos        run_lens[$];
        t_result     due_reports[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            blk_lo        = '0;
            blk_hi        = '0;
            contig_active = 1'b0;
            total_iv      = '0;
            total_cov     = '0;
            total_unc     = '0;
            total_ovh     = '0;
            cnt_oriented  = '0;
            cnt_labelled  = '0;
            cnt_scored    = '0;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function t_total add_total(t_total acc, t_pos len);
            logic [TOT_W:0] sum;
            sum = acc + len;
            return sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
        endfunction

        function t_count add_count(t_count acc, logic bump);
            return (bump && acc != {COUNT_BITS{1'b1}}) ? acc + 1'b1 : acc;
        endfunction

        function t_pos span(t_pos hi, t_pos lo);
            return (hi > lo) ? hi - lo : '0;
        endfunction

        function void emit(t_kind kind, t_pos len);
            run_kinds.push_back(kind);
            run_lens.push_back(len);
            case (kind)
                KIND_INTERVAL:  total_iv  = add_total(total_iv, len);
                KIND_COVERED:   total_cov = add_total(total_cov, len);
                KIND_UNCOVERED: total_unc = add_total(total_unc, len);
                default:        total_ovh = add_total(total_ovh, len);
            endcase
        endfunction

        function void merge_item(t_request r);
            t_result res;
            run_kinds.delete();
            run_lens.delete();
            if (r.op == OP_INTERVAL) begin
                if (!contig_active) begin
                    emit(KIND_INTERVAL, span(r.end_pos, r.begin_pos));
                    if (r.begin_pos != '0) begin
                        emit(KIND_UNCOVERED, r.begin_pos);
                    end
                    blk_lo        = r.begin_pos;
                    blk_hi        = r.end_pos;
                    contig_active = 1'b1;
                end else begin
                    if (blk_hi < r.begin_pos) begin
                        emit(KIND_COVERED, span(blk_hi, blk_lo));
                        emit(KIND_UNCOVERED, r.begin_pos - blk_hi);
                        blk_lo = r.begin_pos;
                        blk_hi = r.end_pos;
                    end else if (r.end_pos > blk_hi) begin
                        blk_hi = r.end_pos;
                    end
                    emit(KIND_INTERVAL, span(r.end_pos, r.begin_pos));
                end
                cnt_oriented = add_count(cnt_oriented, r.oriented);
                cnt_labelled = add_count(cnt_labelled, r.labelled);
                cnt_scored   = add_count(cnt_scored, r.scored);
            end else if (contig_active) begin
                emit(KIND_COVERED, span(blk_hi, blk_lo));
                if (blk_hi < r.clen) begin
                    emit(KIND_UNCOVERED, r.clen - blk_hi);
                end else if (blk_hi > r.clen) begin
                    emit(KIND_OVERHANG, blk_hi - r.clen);
                end
                contig_active = 1'b0;
            end
            // totals on every result are those after the whole item
            foreach (run_kinds[k]) begin
                res.kind       = run_kinds[k];
                res.len        = run_lens[k];
                res.last       = (k == run_kinds.size() - 1);
                res.sum_iv     = total_iv;
                res.sum_cov    = total_cov;
                res.sum_unc    = total_unc;
                res.sum_ovh    = total_ovh;
                res.n_oriented = cnt_oriented;
                res.n_labelled = cnt_labelled;
                res.n_scored   = cnt_scored;
                due_reports.push_back(res);
            end
        endfunction

        function void report_field(string name, logic [63:0] want, logic [63:0] seen);
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected %0d, got %0d", checked, name, want, seen);
            end
        endfunction

        function void check_result(t_result seen);
            t_result want;
            checked++;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with none outstanding: kind %0d length %0d",
                             checked, seen.kind, seen.len);
                end
                return;
            end
            want = due_reports.pop_front();
            if (seen.kind !== want.kind) report_field("result_kind", want.kind, seen.kind);
            if (seen.len !== want.len) report_field("length", want.len, seen.len);
            if (seen.last !== want.last) report_field("last_of_run", want.last, seen.last);
            if (seen.sum_iv !== want.sum_iv) report_field("sum_intervals", want.sum_iv, seen.sum_iv);
            if (seen.sum_cov !== want.sum_cov) report_field("sum_covered", want.sum_cov, seen.sum_cov);
            if (seen.sum_unc !== want.sum_unc)
                report_field("sum_uncovered", want.sum_unc, seen.sum_unc);
            if (seen.sum_ovh !== want.sum_ovh)
                report_field("sum_overhang", want.sum_ovh, seen.sum_ovh);
            if (seen.n_oriented !== want.n_oriented)
                report_field("oriented_count", want.n_oriented, seen.n_oriented);
            if (seen.n_labelled !== want.n_labelled)
                report_field("labelled_count", want.n_labelled, seen.n_labelled);
            if (seen.n_scored !== want.n_scored)
                report_field("scored_count", want.n_scored, seen.n_scored);
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    int unsigned    random_items;
    longint         cycle_count = 0;
    t_result        seen_result;
    coverage_merger book = new();

    icm_in_if  #(.POSITION_BITS(POS_W)) in_if ();
    icm_out_if #(.POSITION_BITS(POS_W), .TOTAL_BITS(TOT_W)) out_if ();

    interval_coverage_merge #(
        .POSITION_BITS(POS_W),
        .TOTAL_BITS   (TOT_W)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, book.due_reports.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stall, check every accepted result
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            seen_result.kind       = out_if.result_kind;
            seen_result.len        = out_if.length;
            seen_result.last       = out_if.last_of_run;
            seen_result.sum_iv     = out_if.sum_intervals;
            seen_result.sum_cov    = out_if.sum_covered;
            seen_result.sum_unc    = out_if.sum_uncovered;
            seen_result.sum_ovh    = out_if.sum_overhang;
            seen_result.n_oriented = out_if.oriented_count;
            seen_result.n_labelled = out_if.labelled_count;
            seen_result.n_scored   = out_if.scored_count;
            book.check_result(seen_result);
        end
    end

    function automatic t_request make_item(t_op op, t_pos b, t_pos e, t_pos c, logic [2:0] flags);
        t_request r;
        r.op        = op;
        r.begin_pos = b;
        r.end_pos   = e;
        r.clen      = c;
        {r.oriented, r.labelled, r.scored} = flags;
        return r;
    endfunction

    // valid is left high after an item so back-to-back items go without a gap
    task automatic send(input t_request r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.operation      <= r.op;
        in_if.interval_begin <= r.begin_pos;
        in_if.interval_end   <= r.end_pos;
        in_if.contig_length  <= r.clen;
        in_if.is_oriented    <= r.oriented;
        in_if.has_label      <= r.labelled;
        in_if.has_score      <= r.scored;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        book.merge_item(r);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (book.due_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one contig of mostly sorted intervals with random content, some stray items mixed in
    task automatic send_random_contig();
        t_request    r;
        t_pos        base;
        t_pos        hi;
        int unsigned n;
        n    = $urandom_range(0, 6);
        base = ($urandom_range(3) == 0) ? t_pos'($urandom()) : t_pos'($urandom_range(0, 200));
        hi   = base;
        for (int unsigned i = 0; i < n; i++) begin
            r.op   = OP_INTERVAL;
            r.clen = t_pos'($urandom());
            {r.oriented, r.labelled, r.scored} = 3'($urandom());
            if ($urandom_range(99) < 8) begin
                r.begin_pos = t_pos'($urandom());
                r.end_pos   = t_pos'($urandom());
            end else begin
                r.begin_pos = t_pos'(base + $urandom_range(0, 24));
                if ($urandom_range(99) < 10) begin
                    r.begin_pos = t_pos'(r.begin_pos - $urandom_range(1, 30));
                end
                if ($urandom_range(99) < 10) begin
                    r.end_pos = t_pos'(r.begin_pos - $urandom_range(1, 8));
                end else begin
                    r.end_pos = t_pos'(r.begin_pos + $urandom_range(0, 40));
                end
            end
            base = r.begin_pos;
            if (r.end_pos > hi) hi = r.end_pos;
            send(r);
            random_items++;
        end
        r.op        = OP_END;
        r.begin_pos = t_pos'($urandom());
        r.end_pos   = t_pos'($urandom());
        {r.oriented, r.labelled, r.scored} = 3'($urandom());
        case ($urandom_range(3))
            0:       r.clen = hi;
            1:       r.clen = t_pos'(hi + $urandom_range(1, 50));
            2:       r.clen = t_pos'(hi - $urandom_range(1, 50));
            default: r.clen = t_pos'($urandom());
        endcase
        send(r);
        if (n != 0) random_items++;
    endtask

    initial begin
        rst_n                <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.operation      <= OP_INTERVAL;
        in_if.interval_begin <= '0;
        in_if.interval_end   <= '0;
        in_if.contig_length  <= '0;
        in_if.is_oriented    <= 1'b0;
        in_if.has_label      <= 1'b0;
        in_if.has_score      <= 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 65;
        random_items  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end with nothing open gives nothing
        send(make_item(OP_END, 7, 3, 50, 3'b111));
        send(make_item(OP_INTERVAL, 0, 10, POS_MAX, 3'b101));
        // touching, then a begin inside the block
        send(make_item(OP_INTERVAL, 10, 15, 0, 3'b010));
        send(make_item(OP_INTERVAL, 3, 12, 0, 3'b100));
        // gap to an interval that ends before it begins
        send(make_item(OP_INTERVAL, 20, 18, 0, 3'b001));
        send(make_item(OP_END, POS_MAX, POS_MAX, 30, 3'b110));
        send(make_item(OP_END, 0, 0, 30, 3'b000));
        send(make_item(OP_INTERVAL, 5, 5, 0, 3'b011));
        send(make_item(OP_END, 0, 0, 5, 3'b000));
        send(make_item(OP_INTERVAL, 1, POS_MAX, 0, 3'b111));
        send(make_item(OP_INTERVAL, POS_MAX, POS_MAX, 0, 3'b000));
        send(make_item(OP_END, 0, 0, 0, 3'b111));
        send(make_item(OP_INTERVAL, POS_MAX, 0, 0, 3'b110));
        send(make_item(OP_INTERVAL, 0, POS_MAX, 0, 3'b001));
        send(make_item(OP_END, 0, 0, POS_MAX, 3'b010));
        send(make_item(OP_INTERVAL, 0, 0, 0, 3'b111));
        send(make_item(OP_INTERVAL, 1, 1, 0, 3'b000));
        send(make_item(OP_END, 0, 0, POS_MAX, 3'b000));
        send(make_item(OP_INTERVAL, 100, 200, POS_MAX, 3'b000));
        send(make_item(OP_END, POS_MAX, POS_MAX, 150, 3'b101));
        send(make_item(OP_INTERVAL, 31'h2AAA_AAAA, 31'h5555_5555, 31'h5555_5555, 3'b010));
        send(make_item(OP_END, 31'h5555_5555, 31'h2AAA_AAAA, 31'h2AAA_AAAA, 3'b100));
        settle();

        while (random_items < PHASE_ITEMS) send_random_contig();
        send_idle_pct = 65;
        recv_idle_pct = 38;
        while (random_items < 2 * PHASE_ITEMS) send_random_contig();
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (random_items < 3 * PHASE_ITEMS) send_random_contig();
        repeat (3) send_random_contig();
        settle();

        if (book.mismatches == 0 && book.due_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
